// ===== hdl/usu_pkg.sv =====
// ----------------------------------------------------------------------------
// usu_pkg
// Shared types, codes and helpers of the string unescape / UTF-8 parser.
// ----------------------------------------------------------------------------
package usu_pkg;

  localparam int unsigned MAX_STRING_LEN_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_END       = 3'd0,
    ST_QUOTE     = 3'd1,
    ST_BAD_ESC   = 3'd2,
    ST_LEAD_ONLY = 3'd3,
    ST_TAIL_ONLY = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MAIN_NONE = 2'd0,
    MAIN_RAW  = 2'd1,
    MAIN_UTF8 = 2'd2
  } main_kind_t;

  // one transaction's worth of work for the back end
  typedef struct packed {
    logic        pre_v;
    logic [7:0]  pre_byte;
    main_kind_t  main_kind;
    logic [20:0] cp;
    logic        st_v;
    status_t     st_code;
    logic [15:0] st_off;
  } cmd_t;

  function automatic logic [7:0] single_escape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h5c:   r = 8'h5c;
      8'h22:   r = 8'h22;
      8'h27:   r = 8'h27;
      8'h2f:   r = 8'h2f;
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h65:   r = 8'h1b;
      8'h66:   r = 8'h0c;
      8'h6e:   r = 8'h0a;
      8'h72:   r = 8'h0d;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0b;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/usu_front.sv =====
// ----------------------------------------------------------------------------
// usu_front
// Accepts bytes, tracks escape state and issues at most one command per byte.
// ----------------------------------------------------------------------------
module usu_front #(
  parameter int unsigned MAX_STRING_LEN = usu_pkg::MAX_STRING_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          is_final,
  input  logic          q_full,
  output logic          push,
  output usu_pkg::cmd_t push_cmd
);

  localparam int unsigned CAP = (MAX_STRING_LEN < 65535) ? MAX_STRING_LEN : 65535;
  localparam logic [15:0] CAP16 = CAP[15:0];

  typedef enum logic [3:0] {
    PH_NORMAL, PH_ESC, PH_HEX2, PH_OCT, PH_U4, PH_U8, PH_LEAD_BS, PH_LEAD_U, PH_TAIL4
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] hex_accum, hex_accum_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [7:0]  octal_value, octal_value_next;
  logic [9:0]  lead_surrogate, lead_surrogate_next;
  logic [15:0] escape_start, escape_start_next;
  logic [15:0] byte_offset;
  logic        stopped, stopped_next;

  usu_pkg::cmd_t c;
  logic        accept, do_normal, hok, is_oct, done_hex;
  logic [3:0]  hv;
  logic [7:0]  lc, esc_r;
  logic [31:0] acc_n;
  logic [15:0] v16;
  logic [10:0] lead_hi;
  logic [16:0] off_p1;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lc     = in_byte | 8'h20;
    hok    = 1'b1;
    hv     = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hv = 4'(in_byte - 8'h30);
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      hv = 4'(lc - 8'h57);
    end else begin
      hok = 1'b0;
    end
    is_oct  = (in_byte >= 8'h30 && in_byte <= 8'h37);
    esc_r   = usu_pkg::single_escape(in_byte);
    acc_n   = {hex_accum[27:0], hv};
    v16     = acc_n[15:0];
    lead_hi = {1'b0, lead_surrogate} + 11'd64;
    off_p1  = {1'b0, byte_offset} + 17'd1;

    phase_next          = phase;
    hex_accum_next      = hex_accum;
    digit_count_next    = digit_count;
    octal_value_next    = octal_value;
    lead_surrogate_next = lead_surrogate;
    escape_start_next   = escape_start;
    stopped_next        = stopped;
    do_normal           = 1'b0;
    done_hex            = 1'b0;
    c                   = '0;

    if (!stopped) begin
      unique case (phase)
        PH_NORMAL: do_normal = 1'b1;
        PH_ESC: begin
          hex_accum_next   = '0;
          digit_count_next = '0;
          if (esc_r != 8'd0) begin
            c.main_kind = usu_pkg::MAIN_RAW;
            c.cp        = {13'd0, esc_r};
            phase_next  = PH_NORMAL;
          end else if (in_byte == 8'h78) begin
            phase_next = PH_HEX2;
          end else if (is_oct) begin
            octal_value_next = {5'd0, in_byte[2:0]};
            digit_count_next = 4'd1;
            phase_next       = PH_OCT;
          end else if (in_byte == 8'h75) begin
            phase_next = PH_U4;
          end else if (in_byte == 8'h55) begin
            phase_next = PH_U8;
          end else begin
            c.st_v = 1'b1; c.st_code = usu_pkg::ST_BAD_ESC;
          end
        end
        PH_HEX2, PH_U4, PH_U8, PH_TAIL4: begin
          if (!hok) begin
            c.st_v    = 1'b1;
            c.st_code = (phase == PH_TAIL4) ? usu_pkg::ST_LEAD_ONLY : usu_pkg::ST_BAD_ESC;
          end else begin
            hex_accum_next   = acc_n;
            digit_count_next = digit_count + 4'd1;
            priority case (phase)
              PH_HEX2: done_hex = (digit_count_next == 4'd2);
              PH_U8:   done_hex = (digit_count_next == 4'd8);
              default: done_hex = (digit_count_next == 4'd4);
            endcase
            if (done_hex) begin
              phase_next = PH_NORMAL;
              priority case (phase)
                PH_HEX2: begin
                  c.main_kind = usu_pkg::MAIN_RAW; c.cp = {13'd0, acc_n[7:0]};
                end
                PH_U8: begin
                  if (acc_n > 32'h0010ffff) begin
                    c.st_v = 1'b1; c.st_code = usu_pkg::ST_TOO_LARGE;
                  end else begin
                    c.main_kind = usu_pkg::MAIN_UTF8; c.cp = acc_n[20:0];
                  end
                end
                PH_U4: begin
                  if (v16 >= 16'hd800 && v16 <= 16'hdbff) begin
                    lead_surrogate_next = v16[9:0];
                    phase_next          = PH_LEAD_BS;
                  end else if (v16 >= 16'hdc00 && v16 <= 16'hdfff) begin
                    c.st_v = 1'b1; c.st_code = usu_pkg::ST_TAIL_ONLY;
                  end else begin
                    c.main_kind = usu_pkg::MAIN_UTF8; c.cp = {5'd0, v16};
                  end
                end
                default: begin
                  if (v16 >= 16'hdc00 && v16 <= 16'hdfff) begin
                    c.main_kind = usu_pkg::MAIN_UTF8; c.cp = {lead_hi, v16[9:0]};
                  end else begin
                    c.st_v = 1'b1; c.st_code = usu_pkg::ST_LEAD_ONLY;
                  end
                end
              endcase
            end
          end
        end
        PH_OCT: begin
          if (is_oct) begin
            octal_value_next = {octal_value[4:0], in_byte[2:0]};
            digit_count_next = digit_count + 4'd1;
            if (digit_count_next >= 4'd3 || octal_value_next >= 8'h20) begin
              c.main_kind = usu_pkg::MAIN_RAW; c.cp = {13'd0, octal_value_next};
              phase_next  = PH_NORMAL;
            end
          end else begin
            c.pre_v = 1'b1; c.pre_byte = octal_value;
            phase_next = PH_NORMAL;
            do_normal  = 1'b1;
          end
        end
        PH_LEAD_BS: begin
          if (in_byte == 8'h5c) phase_next = PH_LEAD_U;
          else begin c.st_v = 1'b1; c.st_code = usu_pkg::ST_LEAD_ONLY; end
        end
        PH_LEAD_U: begin
          if (in_byte == 8'h75) begin
            hex_accum_next = '0; digit_count_next = '0; phase_next = PH_TAIL4;
          end else begin
            c.st_v = 1'b1; c.st_code = usu_pkg::ST_LEAD_ONLY;
          end
        end
        default: do_normal = 1'b1;
      endcase

      if (c.st_v) begin
        c.st_off     = escape_start;
        stopped_next = 1'b1;
        phase_next   = PH_NORMAL;
      end

      if (do_normal) begin
        if (in_byte == 8'h22) begin
          c.st_v = 1'b1; c.st_code = usu_pkg::ST_QUOTE; c.st_off = byte_offset;
          stopped_next = 1'b1;
        end else if (in_byte == 8'h5c) begin
          escape_start_next = byte_offset;
          phase_next        = PH_ESC;
        end else begin
          c.main_kind = usu_pkg::MAIN_RAW; c.cp = {13'd0, in_byte};
        end
      end

      if (is_final && !stopped_next) begin
        c.st_v = 1'b1;
        priority case (phase_next)
          PH_NORMAL: begin
            c.st_code = usu_pkg::ST_END;
            c.st_off  = (off_p1 > {1'b0, CAP16}) ? CAP16 : off_p1[15:0];
          end
          PH_OCT: begin
            c.main_kind = usu_pkg::MAIN_RAW; c.cp = {13'd0, octal_value_next};
            c.st_code   = usu_pkg::ST_END;
            c.st_off    = (off_p1 > {1'b0, CAP16}) ? CAP16 : off_p1[15:0];
          end
          PH_LEAD_BS, PH_LEAD_U, PH_TAIL4: begin
            c.st_code = usu_pkg::ST_LEAD_ONLY; c.st_off = escape_start_next;
          end
          default: begin
            c.st_code = usu_pkg::ST_BAD_ESC; c.st_off = escape_start_next;
          end
        endcase
      end
    end
  end

  assign push     = accept && (c.pre_v || c.st_v || c.main_kind != usu_pkg::MAIN_NONE);
  assign push_cmd = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NORMAL;
      hex_accum      <= '0;
      digit_count    <= '0;
      octal_value    <= '0;
      lead_surrogate <= '0;
      escape_start   <= '0;
      byte_offset    <= '0;
      stopped        <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        phase          <= PH_NORMAL;
        hex_accum      <= '0;
        digit_count    <= '0;
        octal_value    <= '0;
        lead_surrogate <= '0;
        escape_start   <= '0;
        byte_offset    <= '0;
        stopped        <= 1'b0;
      end else begin
        phase          <= phase_next;
        hex_accum      <= hex_accum_next;
        digit_count    <= digit_count_next;
        octal_value    <= octal_value_next;
        lead_surrogate <= lead_surrogate_next;
        escape_start   <= escape_start_next;
        stopped        <= stopped_next;
        if (byte_offset < CAP16) byte_offset <= byte_offset + 16'd1;
      end
    end
  end

endmodule

// ===== hdl/usu_queue.sv =====
// ----------------------------------------------------------------------------
// usu_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module usu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  usu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_v,
  output usu_pkg::cmd_t head
);

  localparam int unsigned AW = $clog2(usu_pkg::QUEUE_DEPTH);

  usu_pkg::cmd_t mem [usu_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full   = (count == (AW+1)'(usu_pkg::QUEUE_DEPTH));
  assign head_v = (count != '0);
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(usu_pkg::QUEUE_DEPTH)) else $error("queue overflow");

endmodule

// ===== hdl/usu_back.sv =====
// ----------------------------------------------------------------------------
// usu_back
// Expands queued commands into output transactions, one per unstalled cycle.
// ----------------------------------------------------------------------------
module usu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_v,
  input  usu_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          kind,
  output logic [2:0]    status,
  output logic [15:0]   stop_offset,
  output logic          run_end
);

  logic [2:0] idx;
  logic [2:0] cnt, mn, pos;
  logic [7:0] mb [4];
  logic [7:0] ub [5];
  logic [20:0] cp;
  logic       load, last, is_st;

  always_comb begin
    cp = head.cp;
    mb[0] = cp[7:0];
    mb[1] = 8'h00;
    mb[2] = 8'h00;
    mb[3] = 8'h00;
    mn    = 3'd0;
    if (head.main_kind == usu_pkg::MAIN_RAW) begin
      mn = 3'd1;
    end else if (head.main_kind == usu_pkg::MAIN_UTF8) begin
      if (cp < 21'h80) begin
        mn = 3'd1;
      end else if (cp < 21'h800) begin
        mn = 3'd2;
        mb[0] = {3'b110, cp[10:6]};
        mb[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        mn = 3'd3;
        mb[0] = {4'b1110, cp[15:12]};
        mb[1] = {2'b10, cp[11:6]};
        mb[2] = {2'b10, cp[5:0]};
      end else begin
        mn = 3'd4;
        mb[0] = {5'b11110, cp[20:18]};
        mb[1] = {2'b10, cp[17:12]};
        mb[2] = {2'b10, cp[11:6]};
        mb[3] = {2'b10, cp[5:0]};
      end
    end
    for (int i = 0; i < 5; i++) ub[i] = 8'h00;
    pos = 3'd0;
    if (head.pre_v) begin
      ub[0] = head.pre_byte;
      pos   = 3'd1;
    end
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < mn) ub[pos + 3'(j)] = mb[j];
    end
    cnt   = pos + mn + 3'(head.st_v);
    last  = (idx == cnt - 3'd1);
    is_st = head.st_v && last;
    load  = head_v && (!out_valid || !out_stall);
    pop   = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 3'd0 : idx + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= is_st ? 8'h00 : ub[idx];
      kind        <= is_st;
      status      <= is_st ? head.st_code : usu_pkg::ST_END;
      stop_offset <= is_st ? head.st_off : 16'd0;
      run_end     <= is_st;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_v |-> idx < cnt) else $error("unit index past command");
  a_idx_zero_idle: assert property (@(posedge clk) disable iff (rst)
    !head_v |-> idx == 3'd0) else $error("unit index left nonzero");
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> (stop_offset == 16'd0 && !run_end))
    else $error("data transaction carries status fields");

endmodule

// ===== hdl/string_unescape_utf8_parser_core.sv =====
// ----------------------------------------------------------------------------
// string_unescape_utf8_parser_core
// Streaming unescaper of quoted string bodies into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one source byte per transaction, with
// is_final on the last byte of a buffer. Output channel (out_valid/
// out_stall): data bytes (kind 0) and status transactions (kind 1,
// run_end 1) carrying status and stop_offset.
// The front end decodes one byte per cycle unless the queue is full and
// pushes at most one command into a four-entry queue; the back end emits one
// output transaction per cycle unless out_stall is high. Results are
// registered at the output. A byte that yields one result sustains one byte
// per cycle when unstalled; one that yields n results (up to 5, e.g. a
// 4-byte UTF-8 sequence plus a status) takes n output transactions, which
// the queue absorbs. in_stall rises only when the queue is full, so receiver
// stalls propagate back through the queue. Reset empties the queue, drops
// the output register and returns the parser to the copy phase at offset 0.
// ----------------------------------------------------------------------------
module string_unescape_utf8_parser_core #(
  parameter int unsigned MAX_STRING_LEN = usu_pkg::MAX_STRING_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        kind,
  output logic [2:0]  status,
  output logic [15:0] stop_offset,
  output logic        run_end
);

  usu_pkg::cmd_t push_cmd, head;
  logic push, q_full, pop, head_v;

  usu_front #(.MAX_STRING_LEN(MAX_STRING_LEN)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .is_final,
    .q_full, .push, .push_cmd
  );

  usu_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full(q_full), .pop, .head_v, .head
  );

  usu_back u_back (
    .clk, .rst, .head_v, .head, .pop, .out_valid, .out_stall,
    .out_byte, .kind, .status, .stop_offset, .run_end
  );

endmodule
